>>> design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 16;

    localparam int DATA_W  = 32;
    localparam int PRIN_W  = 16;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [PRIORITY_BITS-1:0] t_prio;

    // one stored entry, handed between neighboring cells
    typedef struct packed {
        logic [DATA_W-1:0] data;
        t_prio             prio;
    } t_entry;

    // command broadcast to every cell in the row
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cmd;

endpackage

>>> design/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic            i_clk,
    input  spq_pkg::t_cmd   i_cmd,
    input  logic            i_occupied,
    input  spq_pkg::t_entry i_left,
    input  logic            i_left_shift,
    input  spq_pkg::t_entry i_right,
    output spq_pkg::t_entry o_entry,
    output logic            o_shift
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // an entry moves right when the new one sorts ahead of it; equal priority stays
    assign o_shift = !(i_occupied && (r_entry.prio <= i_cmd.item.prio));

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq && o_shift) begin
            n_entry = i_left_shift ? i_left : i_cmd.item;
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> design/spq_out_buf.sv
`timescale 1ns / 1ps

module spq_out_buf (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [spq_pkg::STAT_W-1:0]     i_status,
    input  logic [spq_pkg::DATA_W-1:0]     i_data,
    input  logic [spq_pkg::OCC_W-1:0]      i_occ,
    output logic                           o_full,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [spq_pkg::STAT_W-1:0]     o_status,
    output logic [spq_pkg::DATA_W-1:0]     o_data,
    output logic [spq_pkg::OCC_W-1:0]      o_occ
);
    import spq_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [OCC_W-1:0]  occ;
    } t_res;

    t_res r_main;
    t_res r_skid;
    t_res w_new;
    logic r_main_vld;
    logic r_skid_vld;
    logic w_take;

    assign w_new  = '{status: i_status, data: i_data, occ: i_occ};
    assign w_take = r_main_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_take && r_skid_vld) begin
                r_main     <= r_skid;
                r_skid_vld <= 1'b0;
            end else if (i_load && (!r_main_vld || w_take)) begin
                r_main     <= w_new;
                r_main_vld <= 1'b1;
            end else if (i_load) begin
                r_skid     <= w_new;
                r_skid_vld <= 1'b1;
            end else if (w_take) begin
                r_main_vld <= 1'b0;
            end
        end
    end

    assign o_full   = r_skid_vld;
    assign o_valid  = r_main_vld;
    assign o_status = r_main.status;
    assign o_data   = r_main.data;
    assign o_occ    = r_main.occ;

endmodule

>>> design/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Sorted priority queue, a row of CAPACITY cells kept in ascending priority.
// Input channel: i_valid / o_stall carry one transaction per item:
//   i_operation (enqueue or dequeue), i_item_data, i_item_priority.
// Output channel: o_valid / i_stall carry one result per item:
//   o_status, o_out_data, o_occupancy_after.
// The result of an item is registered in the output buffer once accepted.
// Throughput: one item per cycle while o_stall is low. Every cell compares
//   its own priority with the broadcast one and moves its entry one place in
//   the same cycle, so the whole row updates at once; the next item sees it.
// Equal priorities leave in arrival order; a dequeue on an empty queue
//   returns all ones with the empty status, an enqueue on a full queue is
//   dropped with the full status.
// Reset (synchronous, active low) clears the entry count and the output
//   buffer; cell contents are left as they are and are never read unless
//   written after reset.
// When the receiver stalls, results collect in a two-deep output buffer;
//   o_stall rises only once both places hold a result.

module sorted_priority_queue_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_operation,
    input  logic signed [spq_pkg::DATA_W-1:0]    i_item_data,
    input  logic signed [spq_pkg::PRIN_W-1:0]    i_item_priority,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [spq_pkg::STAT_W-1:0]    o_status,
    output logic signed [spq_pkg::DATA_W-1:0]    o_out_data,
    output logic        [spq_pkg::OCC_W-1:0]     o_occupancy_after
);
    import spq_pkg::*;

    logic                  w_accept;
    logic                  w_empty;
    logic                  w_full;
    t_cmd                  w_cmd;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;
    logic [STAT_W-1:0]     w_status;
    logic [DATA_W-1:0]     w_data;
    logic [OCC_W+COUNT_W-1:0] w_occ_ext;
    logic                  w_buf_full;
    logic [DATA_W-1:0]     w_out_data;

    // neighbor links: index i is what cell i shows; one extra at the far end
    t_entry                w_ent   [CAPACITY+1];
    logic                  w_shift [CAPACITY+1];

    assign o_stall  = w_buf_full;
    assign w_accept = i_valid && !w_buf_full;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == COUNT_W'(CAPACITY));

    // only legal operations reach the row
    assign w_cmd.enq       = w_accept && (i_operation == OP_ENQ) && !w_full;
    assign w_cmd.deq       = w_accept && (i_operation == OP_DEQ) && !w_empty;
    assign w_cmd.item.data = i_item_data;
    assign w_cmd.item.prio = t_prio'(i_item_priority[PRIORITY_BITS-1:0]);

    // far end of the row feeds an arbitrary entry on dequeue; it is never occupied
    assign w_ent[CAPACITY] = w_ent[CAPACITY-1];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic   w_left_shift;
            t_entry w_left;
            if (gi == 0) begin : g_head
                assign w_left_shift = 1'b0;
                assign w_left       = w_cmd.item;
            end else begin : g_body
                assign w_left_shift = w_shift[gi-1];
                assign w_left       = w_ent[gi-1];
            end
            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occupied   (COUNT_W'(gi) < r_count),
                .i_left       (w_left),
                .i_left_shift (w_left_shift),
                .i_right      (w_ent[gi+1]),
                .o_entry      (w_ent[gi]),
                .o_shift      (w_shift[gi])
            );
        end
    endgenerate
    assign w_shift[CAPACITY] = w_shift[CAPACITY-1];

    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result of the accepted item; the front cell is read before it moves
    always_comb begin
        w_status = ST_OK;
        w_data   = '0;
        if (i_operation == OP_DEQ) begin
            if (w_empty) begin
                w_status = ST_EMPTY;
                w_data   = '1;
            end else begin
                w_data = w_ent[0].data;
            end
        end else if (w_full) begin
            w_status = ST_FULL;
        end
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    spq_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_status (w_status),
        .i_data   (w_data),
        .i_occ    (w_occ_ext[OCC_W-1:0]),
        .o_full   (w_buf_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_data   (w_out_data),
        .o_occ    (o_occupancy_after)
    );

    assign o_out_data = w_out_data;

endmodule

>>> design/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [spq_pkg::STAT_W-1:0]   o_status,
    input logic [spq_pkg::DATA_W-1:0]   o_out_data,
    input logic [spq_pkg::OCC_W-1:0]    o_occupancy_after
);
    import spq_pkg::*;

    localparam logic [OCC_W+COUNT_W-1:0] CapExt = (OCC_W + COUNT_W)'(CAPACITY);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_data)
            && $stable(o_occupancy_after))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_out_data == '1) && (o_occupancy_after == '0))
        else $error("empty dequeue result wrong");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL)
            |-> (o_out_data == '0) && (o_occupancy_after == CapExt[OCC_W-1:0]))
        else $error("full enqueue result wrong");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_status          (o_status),
    .o_out_data        (o_out_data),
    .o_occupancy_after (o_occupancy_after)
);
